/* sv/knn_pkg.sv */
`default_nettype none
package knn_pkg;
    localparam int KNN_MAX_REFS   = 1024;
    localparam int KNN_MAX_NBRS   = 16;
    localparam int KNN_DIMS       = 3;
    localparam int KNN_COORD_BITS = 16;

    localparam int IN_COORD_W = 16;
    localparam int K_W        = 5;
    localparam int RANK_OUT_W = 4;
    localparam int IDX_OUT_W  = 10;
    localparam int DIST_OUT_W = 34;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    typedef struct packed {
        logic clear;
        logic append;
        logic query_start;
        logic rd_en;
        logic emit_entry;
        logic emit_special;
        logic special_ovf;
    } t_knn_ctl;

    typedef struct packed {
        logic full;
        logic empty;
        logic pipe_busy;
        logic out_free;
    } t_knn_sts;
endpackage
`default_nettype wire

/* sv/knn_if.sv */
`default_nettype none
interface knn_in_if;
    import knn_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   cmd;
    logic signed [IN_COORD_W-1:0] coord_x;
    logic signed [IN_COORD_W-1:0] coord_y;
    logic signed [IN_COORD_W-1:0] coord_z;
    modport source(output valid, cmd, coord_x, coord_y, coord_z, input ready);
    modport sink(input valid, cmd, coord_x, coord_y, coord_z, output ready);
endinterface

interface knn_out_if;
    import knn_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic [RANK_OUT_W-1:0] rank;
    logic [IDX_OUT_W-1:0]  neighbor_index;
    logic [DIST_OUT_W-1:0] distance;
    logic                  last;
    logic                  overflow;
    modport source(output valid, found, rank, neighbor_index, distance, last, overflow,
                   input ready);
    modport sink(input valid, found, rank, neighbor_index, distance, last, overflow,
                 output ready);
endinterface

interface knn_cfg_if;
    import knn_pkg::*;
    logic           valid;
    logic           ready;
    logic [K_W-1:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

/* sv/knn_ram.sv */
`default_nettype none
module knn_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

/* sv/knn_ctrl.sv */
`default_nettype none
module knn_ctrl #(
    parameter int MAX_REFERENCES = 1024,
    parameter int MAX_NEIGHBORS  = 16,
    parameter int AW    = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1,
    parameter int CNT_W = AW + 1,
    parameter int RW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
    parameter int LEN_W = $clog2(MAX_NEIGHBORS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_in_cmd,
    output logic                   o_in_ready,
    input  wire logic [CNT_W-1:0]  i_count,
    input  wire logic [LEN_W-1:0]  i_len,
    input  wire knn_pkg::t_knn_sts i_sts,
    output knn_pkg::t_knn_ctl      o_ctl,
    output logic      [AW-1:0]     o_addr,
    output logic      [RW-1:0]     o_rank
);
    import knn_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT} t_state;

    t_state         r_state, n_state;
    logic [AW-1:0]  r_addr, n_addr;
    logic [RW-1:0]  r_rank, n_rank;
    logic           accept;

    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign o_addr     = r_addr;
    assign o_rank     = r_rank;

    always_comb begin
        o_ctl   = '0;
        n_state = r_state;
        n_addr  = r_addr;
        n_rank  = r_rank;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_cmd)
                        CMD_CLEAR: o_ctl.clear = 1'b1;
                        CMD_APPEND: begin
                            if (i_sts.full) begin
                                o_ctl.emit_special = 1'b1;
                                o_ctl.special_ovf  = 1'b1;
                            end else begin
                                o_ctl.append = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            if (i_sts.empty) begin
                                o_ctl.emit_special = 1'b1;
                            end else begin
                                o_ctl.query_start = 1'b1;
                                n_addr  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                o_ctl.rd_en = 1'b1;
                if ((CNT_W'(r_addr) + CNT_W'(1)) == i_count) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_rank  = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit_entry = 1'b1;
                    if ((LEN_W'(r_rank) + LEN_W'(1)) == i_len) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rank = r_rank + RW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_rank  <= n_rank;
        end
    end

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_addr) < i_count))
        else $error("scan address past count");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (i_len != '0))
        else $error("emit with empty best list");
    a_query_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.query_start |=> (r_state == S_SCAN && r_addr == '0))
        else $error("query did not start scan at zero");
endmodule
`default_nettype wire

/* sv/knn_dp.sv */
`default_nettype none
module knn_dp #(
    parameter int MAX_REFERENCES = 1024,
    parameter int MAX_NEIGHBORS  = 16,
    parameter int DIMENSIONS     = 3,
    parameter int COORD_BITS     = 16,
    parameter int AW    = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1,
    parameter int CNT_W = AW + 1,
    parameter int RW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1,
    parameter int LEN_W = $clog2(MAX_NEIGHBORS + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [knn_pkg::IN_COORD_W-1:0]    i_coord_x,
    input  wire logic [knn_pkg::IN_COORD_W-1:0]    i_coord_y,
    input  wire logic [knn_pkg::IN_COORD_W-1:0]    i_coord_z,
    input  wire logic                              i_cfg_valid,
    input  wire logic [knn_pkg::K_W-1:0]           i_cfg_data,
    input  wire knn_pkg::t_knn_ctl                 i_ctl,
    input  wire logic [AW-1:0]                     i_addr,
    input  wire logic [RW-1:0]                     i_rank,
    output knn_pkg::t_knn_sts                      o_sts,
    output logic      [CNT_W-1:0]                  o_count,
    output logic      [LEN_W-1:0]                  o_len,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_found,
    output logic      [knn_pkg::RANK_OUT_W-1:0]    o_rank,
    output logic      [knn_pkg::IDX_OUT_W-1:0]     o_neighbor_index,
    output logic      [knn_pkg::DIST_OUT_W-1:0]    o_distance,
    output logic                                   o_last,
    output logic                                   o_overflow
);
    import knn_pkg::*;

    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int DIST_W = 2 * COORD_BITS + 2;

    function automatic logic [COORD_BITS-1:0] fmt(logic [IN_COORD_W-1:0] v);
        logic [IN_COORD_W+COORD_BITS-1:0] e;
        e = {{COORD_BITS{1'b0}}, v};
        return e[COORD_BITS-1:0];
    endfunction

    logic [CNT_W-1:0]        r_count;
    logic [K_W-1:0]          r_k;
    logic [LEN_W-1:0]        k_eff;
    logic [COORD_BITS-1:0]   r_q [3];
    logic [3*COORD_BITS-1:0] rd_data;
    logic                    r_v0, r_v1, r_v2;
    logic [AW-1:0]           r_i0, r_i1, r_i2;
    logic [SQ_W-1:0]         r_sq [3];
    logic [DIST_W-1:0]       r_sum;
    logic [DIST_W-1:0]       r_bd [MAX_NEIGHBORS];
    logic [AW-1:0]           r_bi [MAX_NEIGHBORS];
    logic [LEN_W-1:0]        r_len;
    logic [MAX_NEIGHBORS-1:0] lt;

    knn_ram #(.WIDTH(3 * COORD_BITS), .DEPTH(MAX_REFERENCES), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_ctl.append),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data ({fmt(i_coord_z), fmt(i_coord_y), fmt(i_coord_x)}),
        .i_rd_en   (i_ctl.rd_en),
        .i_rd_addr (i_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        if (r_k == '0) begin
            k_eff = LEN_W'(1);
        end else if (int'(r_k) > MAX_NEIGHBORS) begin
            k_eff = LEN_W'(MAX_NEIGHBORS);
        end else begin
            k_eff = LEN_W'(r_k);
        end
    end

    assign o_count        = r_count;
    assign o_len          = r_len;
    assign o_sts.full     = (r_count == CNT_W'(MAX_REFERENCES));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.pipe_busy = r_v0 | r_v1 | r_v2;
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_k     <= K_W'(1);
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_len   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_k <= i_cfg_data;
            end
            if (i_ctl.clear) begin
                r_count <= '0;
            end else if (i_ctl.append) begin
                r_count <= r_count + CNT_W'(1);
            end
            r_v0 <= i_ctl.rd_en;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (i_ctl.query_start) begin
                r_len <= '0;
            end else if (r_v2 && r_len < k_eff) begin
                r_len <= r_len + LEN_W'(1);
            end
            if (i_ctl.emit_special || i_ctl.emit_entry) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.query_start) begin
            r_q[0] <= fmt(i_coord_x);
            r_q[1] <= fmt(i_coord_y);
            r_q[2] <= fmt(i_coord_z);
        end
        r_i0  <= i_addr;
        r_i1  <= r_i0;
        r_i2  <= r_i1;
        r_sum <= DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]) + DIST_W'(r_sq[2]);
    end

    for (genvar d = 0; d < 3; d++) begin : g_dim
        logic signed [COORD_BITS:0]     diff;
        logic signed [2*COORD_BITS+1:0] prod;
        assign diff = $signed({r_q[d][COORD_BITS-1], r_q[d]})
                    - $signed({rd_data[d*COORD_BITS+COORD_BITS-1],
                               rd_data[d*COORD_BITS +: COORD_BITS]});
        assign prod = diff * diff;
        always_ff @(posedge i_clk) begin
            r_sq[d] <= (d < DIMENSIONS) ? prod[SQ_W-1:0] : '0;
        end
    end

    for (genvar j = 0; j < MAX_NEIGHBORS; j++) begin : g_best
        assign lt[j] = (LEN_W'(j) < r_len) ? (r_sum < r_bd[j]) : 1'b1;
        always_ff @(posedge i_clk) begin
            if (r_v2) begin
                if (lt[j] && (j == 0 || !lt[(j > 0) ? j - 1 : 0])) begin
                    r_bd[j] <= r_sum;
                    r_bi[j] <= r_i2;
                end else if (j > 0 && lt[(j > 0) ? j - 1 : 0]) begin
                    r_bd[j] <= r_bd[(j > 0) ? j - 1 : 0];
                    r_bi[j] <= r_bi[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit_special) begin
            o_found          <= 1'b0;
            o_rank           <= '0;
            o_neighbor_index <= '0;
            o_distance       <= '0;
            o_last           <= 1'b1;
            o_overflow       <= i_ctl.special_ovf;
        end else if (i_ctl.emit_entry) begin
            o_found          <= 1'b1;
            o_rank           <= RANK_OUT_W'(i_rank);
            o_neighbor_index <= IDX_OUT_W'(r_bi[i_rank]);
            o_distance       <= DIST_OUT_W'(r_bd[i_rank]);
            o_last           <= ((LEN_W'(i_rank) + LEN_W'(1)) == r_len);
            o_overflow       <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* sv/k_nearest_neighbor_search.sv */
// Clear and append complete on acceptance; an append to a full store or a
// query on an empty store gives one registered beat.
// A query scans the store (one RAM read per cycle, three-stage distance
// pipeline), then gives one result beat per rank as the output accepts them.
// Reset empties the reference set and sets k to 1; the store itself is not
// cleared and needs no clearing pass.
`default_nettype none
module k_nearest_neighbor_search #(
    parameter int MAX_REFERENCES = knn_pkg::KNN_MAX_REFS,
    parameter int MAX_NEIGHBORS  = knn_pkg::KNN_MAX_NBRS,
    parameter int DIMENSIONS     = knn_pkg::KNN_DIMS,
    parameter int COORD_BITS     = knn_pkg::KNN_COORD_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    knn_in_if.sink    i_in_ch,
    knn_cfg_if.sink   i_cfg_ch,
    knn_out_if.source o_out_ch
);
    import knn_pkg::*;

    localparam int AW    = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
    localparam int CNT_W = AW + 1;
    localparam int RW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int LEN_W = $clog2(MAX_NEIGHBORS + 1);

    t_knn_ctl         ctl;
    t_knn_sts         sts;
    logic [CNT_W-1:0] count;
    logic [LEN_W-1:0] len;
    logic [AW-1:0]    addr;
    logic [RW-1:0]    rank;

    assign i_cfg_ch.ready = 1'b1;

    knn_ctrl #(
        .MAX_REFERENCES(MAX_REFERENCES), .MAX_NEIGHBORS(MAX_NEIGHBORS),
        .AW(AW), .CNT_W(CNT_W), .RW(RW), .LEN_W(LEN_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_cmd   (i_in_ch.cmd),
        .o_in_ready (i_in_ch.ready),
        .i_count    (count),
        .i_len      (len),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_addr     (addr),
        .o_rank     (rank)
    );

    knn_dp #(
        .MAX_REFERENCES(MAX_REFERENCES), .MAX_NEIGHBORS(MAX_NEIGHBORS),
        .DIMENSIONS(DIMENSIONS), .COORD_BITS(COORD_BITS),
        .AW(AW), .CNT_W(CNT_W), .RW(RW), .LEN_W(LEN_W)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_coord_x        (i_in_ch.coord_x),
        .i_coord_y        (i_in_ch.coord_y),
        .i_coord_z        (i_in_ch.coord_z),
        .i_cfg_valid      (i_cfg_ch.valid),
        .i_cfg_data       (i_cfg_ch.data),
        .i_ctl            (ctl),
        .i_addr           (addr),
        .i_rank           (rank),
        .o_sts            (sts),
        .o_count          (count),
        .o_len            (len),
        .o_out_valid      (o_out_ch.valid),
        .i_out_ready      (o_out_ch.ready),
        .o_found          (o_out_ch.found),
        .o_rank           (o_out_ch.rank),
        .o_neighbor_index (o_out_ch.neighbor_index),
        .o_distance       (o_out_ch.distance),
        .o_last           (o_out_ch.last),
        .o_overflow       (o_out_ch.overflow)
    );
endmodule
`default_nettype wire
